@@ hdl/mp3d_pkg.sv @@
`timescale 1ns / 1ps
// mp3d_pkg: shared types and constants of the 3-D max pooling block.
// Used by every module under hdl/; depends on nothing.
package mp3d_pkg;

    // configuration register widths and port geometry
    localparam int CFG_SIZE_W  = 13;
    localparam int CFG_POOL_W  = 9;
    localparam int CFG_MASK_W  = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // output coordinate width
    localparam int COORD_W = 12;

    // front-to-back queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // dimension order, also the bit order of pooled_mask
    localparam int DIM_OUTER  = 0;
    localparam int DIM_MIDDLE = 1;
    localparam int DIM_INNER  = 2;
    localparam int NUM_DIMS   = 3;

    // reset values of the configuration registers
    localparam logic [CFG_SIZE_W-1:0] RST_SIZE_OUTER  = 13'd8;
    localparam logic [CFG_SIZE_W-1:0] RST_SIZE_MIDDLE = 13'd8;
    localparam logic [CFG_SIZE_W-1:0] RST_SIZE_INNER  = 13'd1;
    localparam logic [CFG_POOL_W-1:0] RST_POOL_LEN    = 9'd4;
    localparam logic [CFG_MASK_W-1:0] RST_POOLED_MASK = 3'd7;

    // configuration register index map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SIZE_OUTER  = 3'd0,
        REG_SIZE_MIDDLE = 3'd1,
        REG_SIZE_INNER  = 3'd2,
        REG_POOL_LEN    = 3'd3,
        REG_POOLED_MASK = 3'd4
    } t_cfg_reg;

    // configuration register file
    typedef struct packed {
        logic [CFG_SIZE_W-1:0] size_outer;
        logic [CFG_SIZE_W-1:0] size_middle;
        logic [CFG_SIZE_W-1:0] size_inner;
        logic [CFG_POOL_W-1:0] pool_len;
        logic [CFG_MASK_W-1:0] pooled_mask;
    } t_cfg;

    // what the back end does with a partial maximum
    typedef enum logic {
        OP_START = 1'b0,   // first sample of a window: overwrite
        OP_MERGE = 1'b1    // later sample: keep the larger
    } t_op_kind;

    // control part of one queued operation
    typedef struct packed {
        t_op_kind             kind;
        logic                 emit;
        logic                 frame_end;
        logic [COORD_W-1:0]   out_outer;
        logic [COORD_W-1:0]   out_middle;
        logic [COORD_W-1:0]   out_inner;
    } t_op_ctrl;

endpackage

@@ hdl/mp3d_front.sv @@
`timescale 1ns / 1ps
// mp3d_front: position tracking and window classification of incoming samples.
// Depends on mp3d_pkg; feeds mp3d_queue.
module mp3d_front #(
    parameter int MAX_EXTENT  = 4096,
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mp3d_pkg::t_cfg                   i_cfg,
    input  logic                             i_clear,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  logic                             i_q_full,
    output logic                             o_push,
    output mp3d_pkg::t_op_ctrl               o_ctrl,
    output logic [$clog2(STORE_DEPTH)-1:0]   o_addr,
    output logic signed [SAMPLE_BITS-1:0]    o_sample
);
    import mp3d_pkg::*;

    localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
    localparam int POS_W  = $clog2(MAX_EXTENT);
    localparam int SUM_W  = ((EXT_W > CFG_POOL_W) ? EXT_W : CFG_POOL_W) + 2;
    localparam int ROW_W  = 2 * POS_W + 1;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // per-dimension counters: position, offset in window, window index, window start
    logic [POS_W-1:0]      r_pos  [NUM_DIMS];
    logic [CFG_POOL_W-1:0] r_rem  [NUM_DIMS];
    logic [POS_W-1:0]      r_widx [NUM_DIMS];
    logic [POS_W-1:0]      r_wst  [NUM_DIMS];
    logic [POS_W-1:0]      n_pos  [NUM_DIMS];
    logic [CFG_POOL_W-1:0] n_rem  [NUM_DIMS];
    logic [POS_W-1:0]      n_widx [NUM_DIMS];
    logic [POS_W-1:0]      n_wst  [NUM_DIMS];

    // store row base and count of whole inner windows in the current row
    logic [ROW_W-1:0] r_row_base, n_row_base;
    logic [EXT_W-1:0] r_icnt, n_icnt;

    logic [CFG_SIZE_W-1:0] raw_ext  [NUM_DIMS];
    logic [EXT_W-1:0]      ext      [NUM_DIMS];
    logic [CFG_POOL_W-1:0] win      [NUM_DIMS];
    logic [CFG_POOL_W-1:0] pool_eff;
    logic [NUM_DIMS-1:0]   in_win, last_win, at_start, at_end, wrap, step;
    logic                  accept;
    logic [EXT_W-1:0]      ni_row;
    logic [ROW_W-1:0]      addr;
    logic                  in_store;

    assign raw_ext[DIM_OUTER]  = i_cfg.size_outer;
    assign raw_ext[DIM_MIDDLE] = i_cfg.size_middle;
    assign raw_ext[DIM_INNER]  = i_cfg.size_inner;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // effective extents and window lengths, window tests per dimension
    always_comb begin
        pool_eff = (i_cfg.pool_len == '0) ? CFG_POOL_W'(1) : i_cfg.pool_len;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (raw_ext[d] == '0) begin
                ext[d] = EXT_W'(1);
            end else if (32'(raw_ext[d]) > 32'(MAX_EXTENT)) begin
                ext[d] = EXT_W'(MAX_EXTENT);
            end else begin
                ext[d] = EXT_W'(raw_ext[d]);
            end
            win[d] = (i_cfg.pooled_mask[d] && ext[d] != EXT_W'(1)) ? pool_eff
                                                                    : CFG_POOL_W'(1);
            in_win[d]   = (SUM_W'(r_wst[d]) + SUM_W'(win[d])) <= SUM_W'(ext[d]);
            last_win[d] = in_win[d] &&
                          ((SUM_W'(r_wst[d]) + SUM_W'({win[d], 1'b0})) > SUM_W'(ext[d]));
            at_start[d] = (r_rem[d] == '0);
            at_end[d]   = (r_rem[d] == CFG_POOL_W'(win[d] - 1'b1));
            wrap[d]     = (EXT_W'(r_pos[d]) + EXT_W'(1)) >= ext[d];
        end
    end

    // carry chain: inner steps every sample, outer ones on wrap
    assign step[DIM_INNER]  = accept;
    assign step[DIM_MIDDLE] = accept && wrap[DIM_INNER];
    assign step[DIM_OUTER]  = step[DIM_MIDDLE] && wrap[DIM_MIDDLE];

    // counter next state
    always_comb begin
        for (int d = 0; d < NUM_DIMS; d++) begin
            n_pos[d]  = r_pos[d];
            n_rem[d]  = r_rem[d];
            n_widx[d] = r_widx[d];
            n_wst[d]  = r_wst[d];
            if (i_clear || (step[d] && wrap[d])) begin
                n_pos[d]  = '0;
                n_rem[d]  = '0;
                n_widx[d] = '0;
                n_wst[d]  = '0;
            end else if (step[d]) begin
                n_pos[d] = r_pos[d] + POS_W'(1);
                if (at_end[d]) begin
                    n_rem[d]  = '0;
                    n_widx[d] = r_widx[d] + POS_W'(1);
                    n_wst[d]  = POS_W'(SUM_W'(r_wst[d]) + SUM_W'(win[d]));
                end else begin
                    n_rem[d] = r_rem[d] + CFG_POOL_W'(1);
                end
            end
        end
    end

    // inner window count per row, and store row base per middle window
    always_comb begin
        ni_row     = r_icnt + EXT_W'(at_end[DIM_INNER] && in_win[DIM_INNER]);
        n_icnt     = r_icnt;
        n_row_base = r_row_base;
        if (i_clear || step[DIM_MIDDLE]) begin
            n_icnt = '0;
        end else if (accept && at_end[DIM_INNER] && in_win[DIM_INNER]) begin
            n_icnt = r_icnt + EXT_W'(1);
        end
        if (i_clear || (step[DIM_MIDDLE] && wrap[DIM_MIDDLE])) begin
            n_row_base = '0;
        end else if (step[DIM_MIDDLE] && at_end[DIM_MIDDLE]) begin
            n_row_base = r_row_base + ROW_W'(ni_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_pos[d]  <= '0;
                r_rem[d]  <= '0;
                r_widx[d] <= '0;
                r_wst[d]  <= '0;
            end
            r_icnt     <= '0;
            r_row_base <= '0;
        end else begin
            r_pos      <= n_pos;
            r_rem      <= n_rem;
            r_widx     <= n_widx;
            r_wst      <= n_wst;
            r_icnt     <= n_icnt;
            r_row_base <= n_row_base;
        end
    end

    // classify the sample into a store operation
    assign addr     = r_row_base + ROW_W'(r_widx[DIM_INNER]);
    assign in_store = 64'(addr) < 64'(STORE_DEPTH);

    always_comb begin
        o_push            = accept && (&in_win) && in_store;
        o_ctrl.kind       = (&at_start) ? OP_START : OP_MERGE;
        o_ctrl.emit       = &at_end;
        o_ctrl.frame_end  = last_win[DIM_OUTER] &&
                            ((last_win[DIM_MIDDLE] && last_win[DIM_INNER]) ||
                             (64'(addr) == 64'(STORE_DEPTH - 1)));
        o_ctrl.out_outer  = COORD_W'(r_widx[DIM_OUTER]);
        o_ctrl.out_middle = COORD_W'(r_widx[DIM_MIDDLE]);
        o_ctrl.out_inner  = COORD_W'(r_widx[DIM_INNER]);
        o_addr            = ADDR_W'(addr);
        o_sample          = i_sample;
    end

endmodule

@@ hdl/mp3d_queue.sv @@
`timescale 1ns / 1ps
// mp3d_queue: short FIFO of store operations between front and back end.
// Depends on mp3d_pkg.
module mp3d_queue #(
    parameter int ADDR_W      = 12,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  mp3d_pkg::t_op_ctrl             i_ctrl,
    input  logic [ADDR_W-1:0]              i_addr,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic                           o_empty,
    output mp3d_pkg::t_op_ctrl             o_ctrl,
    output logic [ADDR_W-1:0]              o_addr,
    output logic signed [SAMPLE_BITS-1:0]  o_sample
);
    import mp3d_pkg::*;

    t_op_ctrl                  r_ctrl   [QUEUE_DEPTH];
    logic [ADDR_W-1:0]         r_addr   [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_sample [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0]    r_count;

    assign o_full   = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_ctrl   = r_ctrl[r_rd_ptr];
    assign o_addr   = r_addr[r_rd_ptr];
    assign o_sample = r_sample[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctrl[r_wr_ptr]   <= i_ctrl;
            r_addr[r_wr_ptr]   <= i_addr;
            r_sample[r_wr_ptr] <= i_sample;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("word pushed into a full queue");

endmodule

@@ hdl/mp3d_back.sv @@
`timescale 1ns / 1ps
// mp3d_back: read-modify-write of partial maxima and the result register.
// Depends on mp3d_pkg; drains mp3d_queue.
module mp3d_back #(
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    output logic                                o_pop,
    input  mp3d_pkg::t_op_ctrl                  i_q_ctrl,
    input  logic [$clog2(STORE_DEPTH)-1:0]      i_q_addr,
    input  logic signed [SAMPLE_BITS-1:0]       i_q_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_max_value,
    output logic [mp3d_pkg::COORD_W-1:0]        o_out_outer,
    output logic [mp3d_pkg::COORD_W-1:0]        o_out_middle,
    output logic [mp3d_pkg::COORD_W-1:0]        o_out_inner,
    output logic                                o_frame_end
);
    import mp3d_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // partial maximum store
    logic signed [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];

    // execute stage
    logic                          r_s2_valid;
    t_op_ctrl                      r_s2_ctrl;
    logic [ADDR_W-1:0]             r_s2_addr;
    logic signed [SAMPLE_BITS-1:0] r_s2_sample;
    logic signed [SAMPLE_BITS-1:0] r_rd_data;

    // last write, covers a read that raced it
    logic                          r_fwd_valid;
    logic [ADDR_W-1:0]             r_fwd_addr;
    logic signed [SAMPLE_BITS-1:0] r_fwd_data;

    // result register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_max_value;
    logic [COORD_W-1:0]            r_out_outer, r_out_middle, r_out_inner;
    logic                          r_frame_end;

    logic                          out_free, s2_fire;
    logic signed [SAMPLE_BITS-1:0] old_val, new_val;

    // compare against the stored or forwarded maximum
    always_comb begin
        old_val  = (r_fwd_valid && r_fwd_addr == r_s2_addr) ? r_fwd_data : r_rd_data;
        new_val  = (r_s2_ctrl.kind == OP_START || r_s2_sample > old_val) ? r_s2_sample
                                                                        : old_val;
        out_free = !r_out_valid || !i_out_stall;
        s2_fire  = r_s2_valid && (!r_s2_ctrl.emit || out_free);
        o_pop    = !i_q_empty && (!r_s2_valid || s2_fire);
    end

    // memory: read on pop, write on execute
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[i_q_addr];
        end
        if (s2_fire) begin
            r_mem[r_s2_addr] <= new_val;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_fwd_valid <= 1'b1;
            end
            if (s2_fire && r_s2_ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2_ctrl   <= i_q_ctrl;
            r_s2_addr   <= i_q_addr;
            r_s2_sample <= i_q_sample;
        end
        if (s2_fire) begin
            r_fwd_addr <= r_s2_addr;
            r_fwd_data <= new_val;
        end
        if (s2_fire && r_s2_ctrl.emit) begin
            r_max_value  <= new_val;
            r_out_outer  <= r_s2_ctrl.out_outer;
            r_out_middle <= r_s2_ctrl.out_middle;
            r_out_inner  <= r_s2_ctrl.out_inner;
            r_frame_end  <= r_s2_ctrl.frame_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_max_value  = r_max_value;
    assign o_out_outer  = r_out_outer;
    assign o_out_middle = r_out_middle;
    assign o_out_inner  = r_out_inner;
    assign o_frame_end  = r_frame_end;

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && r_s2_ctrl.emit) |=> r_out_valid)
        else $error("emitted window lost before result register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_s2_valid) |-> s2_fire)
        else $error("execute stage overwritten while held");

    a_hold_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s2_fire) |=> (r_s2_valid && $stable(r_s2_addr)))
        else $error("held operation changed");

endmodule

@@ hdl/max_pooling_3d.sv @@
`timescale 1ns / 1ps
// max_pooling_3d: top level, configuration registers and front/queue/back.
// Depends on mp3d_pkg, mp3d_front, mp3d_queue, mp3d_back.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------
//   in      | in        | i_in_valid / o_in_stall    | i_sample
//   out     | out       | o_out_valid / i_out_stall  | o_max_value, o_out_*, o_frame_end
//   cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One sample per cycle unless the queue is full; the store does one read and one
// write per cycle, with the last write forwarded to the next read of the same entry.
// A result passes through the queue, the execute stage and the result register.
// Reset is synchronous; the partial maximum store needs no clearing pass.
// A four-word queue parts the sample counters from the store, so output stalls
// stop input only once the queue fills.
module max_pooling_3d #(
    parameter int MAX_EXTENT  = 4096,
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_max_value,
    output logic [mp3d_pkg::COORD_W-1:0]         o_out_outer,
    output logic [mp3d_pkg::COORD_W-1:0]         o_out_middle,
    output logic [mp3d_pkg::COORD_W-1:0]         o_out_inner,
    output logic                                 o_frame_end,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mp3d_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mp3d_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mp3d_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    t_cfg r_cfg, n_cfg;
    logic cfg_hit;

    t_op_ctrl                      f_ctrl, q_ctrl;
    logic [ADDR_W-1:0]             f_addr, q_addr;
    logic signed [SAMPLE_BITS-1:0] f_sample, q_sample;
    logic                          f_push, q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    // register write decode; a hit also restarts the frame
    always_comb begin
        n_cfg   = r_cfg;
        cfg_hit = 1'b0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SIZE_OUTER: begin
                    n_cfg.size_outer = i_cfg_data;
                    cfg_hit          = 1'b1;
                end
                REG_SIZE_MIDDLE: begin
                    n_cfg.size_middle = i_cfg_data;
                    cfg_hit           = 1'b1;
                end
                REG_SIZE_INNER: begin
                    n_cfg.size_inner = i_cfg_data;
                    cfg_hit          = 1'b1;
                end
                REG_POOL_LEN: begin
                    n_cfg.pool_len = i_cfg_data[CFG_POOL_W-1:0];
                    cfg_hit        = 1'b1;
                end
                REG_POOLED_MASK: begin
                    n_cfg.pooled_mask = i_cfg_data[CFG_MASK_W-1:0];
                    cfg_hit           = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_outer  <= RST_SIZE_OUTER;
            r_cfg.size_middle <= RST_SIZE_MIDDLE;
            r_cfg.size_inner  <= RST_SIZE_INNER;
            r_cfg.pool_len    <= RST_POOL_LEN;
            r_cfg.pooled_mask <= RST_POOLED_MASK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mp3d_front #(
        .MAX_EXTENT  (MAX_EXTENT),
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_clear    (cfg_hit),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_q_full   (q_full),
        .o_push     (f_push),
        .o_ctrl     (f_ctrl),
        .o_addr     (f_addr),
        .o_sample   (f_sample)
    );

    mp3d_queue #(
        .ADDR_W      (ADDR_W),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_ctrl   (f_ctrl),
        .i_addr   (f_addr),
        .i_sample (f_sample),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_empty  (q_empty),
        .o_ctrl   (q_ctrl),
        .o_addr   (q_addr),
        .o_sample (q_sample)
    );

    mp3d_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .o_pop        (q_pop),
        .i_q_ctrl     (q_ctrl),
        .i_q_addr     (q_addr),
        .i_q_sample   (q_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_max_value  (o_max_value),
        .o_out_outer  (o_out_outer),
        .o_out_middle (o_out_middle),
        .o_out_inner  (o_out_inner),
        .o_frame_end  (o_frame_end)
    );

endmodule
